// File: hdl/rdcs_pkg.sv
// ----------------------------------------------------------------------------
// rdcs_pkg
// Types and constants for the reliable datagram channel sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdcs_pkg;

    localparam int SEQ_W       = 31;
    localparam int LEN_W       = 13;
    localparam int WORD_W      = 32;
    localparam int TAG_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int SUM_W       = 17;

    localparam logic [SUM_W-1:0] MAX_PACKET_BYTES    = 17'd4096;
    localparam logic [SUM_W-1:0] LEGACY_PACKET_BYTES = 17'd1400;
    localparam logic [SUM_W-1:0] HEADER_BYTES        = 17'd8;
    localparam logic [TAG_W-1:0] SHORT_TAG_MAX       = 16'h00FF;

    // func codes
    localparam logic FUNC_TX = 1'b0;
    localparam logic FUNC_RX = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_STALE     = 2'd3;

    // qport field sizes
    localparam logic [1:0] PORT_NONE  = 2'd0;
    localparam logic [1:0] PORT_SHORT = 2'd1;
    localparam logic [1:0] PORT_LONG  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IS_CLIENT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXTENDED  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_TAG  = 2'd2;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] tx_seq_word;
        logic [WORD_W-1:0] tx_ack_word;
        logic [1:0]        port_field_bytes;
        logic              tx_reliable_flag;
        logic [LEN_W-1:0]  reliable_bytes;
        logic              took_pending;
        logic [LEN_W-1:0]  packet_bytes;
        logic              accepted;
        logic              rx_reliable_flag;
        logic [SEQ_W-1:0]  dropped_count;
    } result_t;

endpackage

// File: hdl/reliable_datagram_channel_sequencer.sv
// ----------------------------------------------------------------------------
// reliable_datagram_channel_sequencer
// Header and bookkeeping engine for a sequenced datagram channel.
// Each input transaction passes the input register, then the result register,
// before result valid; throughput: one transaction per cycle unless out_ready stalls.
// The state update for one item is finished in the cycle it leaves the input
// register, so the next item sees it without a bubble.
// Reset (rst_n low, asynchronous) empties both stages, clears configuration,
// and sets out_sequence to 1 with all other channel state at 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reliable_datagram_channel_sequencer
    import rdcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TAG_W-1:0]       cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   func,
    input  logic [LEN_W-1:0]       pending_bytes,
    input  logic                   pending_overflowed,
    input  logic [LEN_W-1:0]       unreliable_bytes,
    input  logic [WORD_W-1:0]      rx_seq_word,
    input  logic [WORD_W-1:0]      rx_ack_word,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [WORD_W-1:0]      tx_seq_word,
    output logic [WORD_W-1:0]      tx_ack_word,
    output logic [1:0]             port_field_bytes,
    output logic                   tx_reliable_flag,
    output logic [LEN_W-1:0]       reliable_bytes,
    output logic                   took_pending,
    output logic [LEN_W-1:0]       packet_bytes,
    output logic                   accepted,
    output logic                   rx_reliable_flag,
    output logic [SEQ_W-1:0]       dropped_count
);

    // configuration
    logic             is_client_reg;
    logic             extended_reg;
    logic [TAG_W-1:0] port_tag_reg;

    // input stage
    logic              s1_valid_reg;
    logic              s1_func_reg;
    logic [LEN_W-1:0]  s1_pending_reg;
    logic              s1_overflow_reg;
    logic [LEN_W-1:0]  s1_unrel_reg;
    logic [WORD_W-1:0] s1_seq_word_reg;
    logic [WORD_W-1:0] s1_ack_word_reg;

    // channel state
    logic [SEQ_W-1:0] out_sequence_reg, out_sequence_next;
    logic [SEQ_W-1:0] in_sequence_reg, in_sequence_next;
    logic             reliable_bit_reg, reliable_bit_next;
    logic             in_reliable_bit_reg, in_reliable_bit_next;
    logic [SEQ_W-1:0] last_sent_reg, last_sent_next;
    logic [SEQ_W-1:0] in_ack_seq_reg, in_ack_seq_next;
    logic             in_ack_bit_reg, in_ack_bit_next;
    logic [LEN_W-1:0] rel_len_reg, rel_len_next;

    // result stage
    logic    out_valid_reg;
    result_t res_reg, res_next;

    logic in_fire, s1_fire, s1_advance;

    // transmit terms
    logic             take;
    logic             resend;
    logic             sr;
    logic [LEN_W-1:0] slot_len;
    logic [LEN_W-1:0] rel;
    logic [SEQ_W-1:0] seq_inc;
    logic [1:0]       tx_port;
    logic [SUM_W-1:0] total;
    logic [SUM_W-1:0] limit;

    // receive terms
    logic [SEQ_W-1:0] rx_seq;
    logic [SEQ_W-1:0] rx_ack;
    logic             rx_stale;
    logic [1:0]       rx_port;

    assign s1_advance = !out_valid_reg || out_ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_client_reg <= 1'b0;
            extended_reg  <= 1'b0;
            port_tag_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IS_CLIENT: is_client_reg <= cfg_data[0];
                CFG_EXTENDED:  extended_reg  <= cfg_data[0];
                CFG_PORT_TAG:  port_tag_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg     <= func;
            s1_pending_reg  <= pending_bytes;
            s1_overflow_reg <= pending_overflowed;
            s1_unrel_reg    <= unreliable_bytes;
            s1_seq_word_reg <= rx_seq_word;
            s1_ack_word_reg <= rx_ack_word;
        end
    end

    // transmit datapath
    always_comb
    begin
        take     = (rel_len_reg == '0) && (s1_pending_reg != '0);
        resend   = (in_ack_seq_reg > last_sent_reg) && (in_ack_bit_reg != reliable_bit_reg);
        sr       = resend || take;
        slot_len = take ? s1_pending_reg : rel_len_reg;
        rel      = sr ? slot_len : '0;
        seq_inc  = out_sequence_reg + 1'b1;

        tx_port = PORT_NONE;
        if (is_client_reg)
        begin
            if (!extended_reg)
                tx_port = PORT_LONG;
            else if (port_tag_reg != '0)
                tx_port = PORT_SHORT;
        end

        total = HEADER_BYTES + {15'd0, tx_port} + {4'd0, rel} + {4'd0, s1_unrel_reg};
        limit = extended_reg ? MAX_PACKET_BYTES : LEGACY_PACKET_BYTES;
    end

    // receive datapath
    always_comb
    begin
        rx_seq   = s1_seq_word_reg[SEQ_W-1:0];
        rx_ack   = s1_ack_word_reg[SEQ_W-1:0];
        rx_stale = rx_seq <= in_sequence_reg;

        rx_port = PORT_NONE;
        if (!is_client_reg)
        begin
            if (!extended_reg || (port_tag_reg > SHORT_TAG_MAX))
                rx_port = PORT_LONG;
            else if (port_tag_reg != '0)
                rx_port = PORT_SHORT;
        end
    end

    // result and state update
    always_comb
    begin
        res_next             = '0;
        out_sequence_next    = out_sequence_reg;
        in_sequence_next     = in_sequence_reg;
        reliable_bit_next    = reliable_bit_reg;
        in_reliable_bit_next = in_reliable_bit_reg;
        last_sent_next       = last_sent_reg;
        in_ack_seq_next      = in_ack_seq_reg;
        in_ack_bit_next      = in_ack_bit_reg;
        rel_len_next         = rel_len_reg;

        if (s1_func_reg == FUNC_RX)
        begin
            res_next.port_field_bytes = rx_port;
            res_next.rx_reliable_flag = s1_seq_word_reg[WORD_W-1];
            if (rx_stale)
            begin
                res_next.status = ST_STALE;
            end
            else
            begin
                res_next.status        = ST_OK;
                res_next.accepted      = 1'b1;
                res_next.dropped_count = rx_seq - in_sequence_reg - 1'b1;
                if (s1_ack_word_reg[WORD_W-1] == reliable_bit_reg)
                    rel_len_next = '0;
                in_sequence_next = rx_seq;
                in_ack_seq_next  = rx_ack;
                in_ack_bit_next  = s1_ack_word_reg[WORD_W-1];
                if (s1_seq_word_reg[WORD_W-1])
                    in_reliable_bit_next = !in_reliable_bit_reg;
            end
        end
        else if (s1_overflow_reg)
        begin
            res_next.status = ST_OVERFLOW;
        end
        else
        begin
            res_next.tx_seq_word      = {sr, out_sequence_reg};
            res_next.tx_ack_word      = {in_reliable_bit_reg, in_sequence_reg};
            res_next.port_field_bytes = tx_port;
            res_next.tx_reliable_flag = sr;
            res_next.reliable_bytes   = rel;
            res_next.took_pending     = take;
            if (total > limit)
            begin
                res_next.status = ST_TOO_LARGE;
            end
            else
            begin
                res_next.status       = ST_OK;
                res_next.packet_bytes = total[LEN_W-1:0];
            end
            out_sequence_next = seq_inc;
            if (take)
            begin
                rel_len_next      = s1_pending_reg;
                reliable_bit_next = !reliable_bit_reg;
            end
            if (sr)
                last_sent_next = seq_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_sequence_reg    <= SEQ_W'(1);
            in_sequence_reg     <= '0;
            reliable_bit_reg    <= 1'b0;
            in_reliable_bit_reg <= 1'b0;
            last_sent_reg       <= '0;
            in_ack_seq_reg      <= '0;
            in_ack_bit_reg      <= 1'b0;
            rel_len_reg         <= '0;
        end
        else if (s1_fire)
        begin
            out_sequence_reg    <= out_sequence_next;
            in_sequence_reg     <= in_sequence_next;
            reliable_bit_reg    <= reliable_bit_next;
            in_reliable_bit_reg <= in_reliable_bit_next;
            last_sent_reg       <= last_sent_next;
            in_ack_seq_reg      <= in_ack_seq_next;
            in_ack_bit_reg      <= in_ack_bit_next;
            rel_len_reg         <= rel_len_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = res_reg.status;
    assign tx_seq_word      = res_reg.tx_seq_word;
    assign tx_ack_word      = res_reg.tx_ack_word;
    assign port_field_bytes = res_reg.port_field_bytes;
    assign tx_reliable_flag = res_reg.tx_reliable_flag;
    assign reliable_bytes   = res_reg.reliable_bytes;
    assign took_pending     = res_reg.took_pending;
    assign packet_bytes     = res_reg.packet_bytes;
    assign accepted         = res_reg.accepted;
    assign rx_reliable_flag = res_reg.rx_reliable_flag;
    assign dropped_count    = res_reg.dropped_count;

    // advance the sequence exactly once per good transmit
    a_seq_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_func_reg == FUNC_TX && !s1_overflow_reg)
        |=> out_sequence_reg == SEQ_W'($past(out_sequence_reg) + 1'b1))
        else $error("out_sequence did not advance on transmit");

    // hold receive state on a stale header
    a_stale_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_func_reg == FUNC_RX && rx_stale)
        |=> $stable(in_sequence_reg) && $stable(rel_len_reg))
        else $error("stale header changed receive state");

    // an accepted header always moves in_sequence forward
    a_rx_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_func_reg == FUNC_RX && !rx_stale)
        |=> in_sequence_reg > $past(in_sequence_reg))
        else $error("accepted header did not advance in_sequence");

    // stall input only when both stages are full and the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a full pipeline");

    // a stale result never reports acceptance
    a_stale_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.status == ST_STALE) |-> !res_reg.accepted)
        else $error("stale result marked accepted");

endmodule
